@@ design/line_pixel_rasterizer_macros.svh @@
// Assertion macros used by the line pixel rasterizer top level.
`ifndef LINE_PIXEL_RASTERIZER_MACROS_SVH
`define LINE_PIXEL_RASTERIZER_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LPR_ASSERT_IMPL(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LPR_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/lpr_pkg.sv @@
// Types and constants shared by the line pixel rasterizer modules.
`timescale 1ns / 1ps

package lpr_pkg;

    localparam int COORD_W = 6;
    localparam int PIX_W   = 8;
    localparam int WIN_W   = 7;
    localparam int ERR_W   = 10;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [PIX_W-1:0]   pix_t;
    typedef logic [WIN_W-1:0]   win_t;
    typedef logic signed [ERR_W-1:0] err_t;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_WIN_W = 2'd0;
    localparam logic [1:0] REG_WIN_H = 2'd1;
    localparam logic [1:0] REG_X_OFF = 2'd2;
    localparam logic [1:0] REG_Y_OFF = 2'd3;

    // A classified line request as it sits in the queue.
    typedef struct packed {
        coord_t x0;
        coord_t y0;
        coord_t x1;
        coord_t y1;
        coord_t dx;
        coord_t dy;
        logic   x_dec;
        logic   y_dec;
    } lpr_cmd_t;

    // Window and offset settings.
    typedef struct packed {
        win_t win_w;
        win_t win_h;
        pix_t x_off;
        pix_t y_off;
    } lpr_cfg_t;

    // Queue fill status.
    typedef struct packed {
        logic full;
        logic empty;
    } lpr_qstat_t;

endpackage

@@ design/lpr_front.sv @@
// Front end: accepts line requests, clamps endpoints and works out deltas and directions.
`timescale 1ns / 1ps

module lpr_front #(
    parameter int COORD_SPAN = 64
) (
    input  logic               start,
    input  lpr_pkg::coord_t    start_x,
    input  lpr_pkg::coord_t    start_y,
    input  lpr_pkg::coord_t    end_x,
    input  lpr_pkg::coord_t    end_y,
    input  lpr_pkg::lpr_qstat_t qstat,
    output logic               busy,
    output logic               push,
    output lpr_pkg::lpr_cmd_t  cmd
);
    import lpr_pkg::*;

    localparam coord_t MAX_C = coord_t'(COORD_SPAN - 1);

    coord_t x0;
    coord_t y0;
    coord_t x1;
    coord_t y1;

    // Saturate endpoints that lie beyond the coordinate span.
    always_comb
    begin
        x0 = (start_x > MAX_C) ? MAX_C : start_x;
        y0 = (start_y > MAX_C) ? MAX_C : start_y;
        x1 = (end_x > MAX_C) ? MAX_C : end_x;
        y1 = (end_y > MAX_C) ? MAX_C : end_y;
    end

    // Absolute deltas and step directions for the walk.
    always_comb
    begin
        cmd.x0    = x0;
        cmd.y0    = y0;
        cmd.x1    = x1;
        cmd.y1    = y1;
        cmd.dx    = (x1 > x0) ? coord_t'(x1 - x0) : coord_t'(x0 - x1);
        cmd.dy    = (y1 > y0) ? coord_t'(y1 - y0) : coord_t'(y0 - y1);
        cmd.x_dec = !(x0 < x1);
        cmd.y_dec = !(y0 < y1);
    end

    // A request is taken whenever the queue has room.
    assign busy = qstat.full;
    assign push = start && !qstat.full;

endmodule

@@ design/lpr_queue.sv @@
// Two-entry queue of classified line requests between front end and walker.
`timescale 1ns / 1ps

module lpr_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  lpr_pkg::lpr_cmd_t   wr_cmd,
    input  logic                pop,
    output lpr_pkg::lpr_cmd_t   head,
    output lpr_pkg::lpr_qstat_t qstat,
    output logic [1:0]          count
);
    import lpr_pkg::*;

    lpr_cmd_t   entry_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    // Pointer and fill count update.
    always_comb
    begin
        wr_ptr_next = push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= wr_cmd;
        end
    end

    assign head        = entry_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == 2'd2);
    assign qstat.empty = (count_reg == 2'd0);
    assign count       = count_reg;

endmodule

@@ design/lpr_walk.sv @@
// Back end: runs the Bresenham error walk and emits one point per cycle.
`timescale 1ns / 1ps

module lpr_walk (
    input  logic                clk,
    input  logic                rst_n,
    input  lpr_pkg::lpr_cfg_t   cfg,
    input  lpr_pkg::lpr_qstat_t qstat,
    input  lpr_pkg::lpr_cmd_t   head,
    output logic                pop,
    output logic                active,
    output logic                result_valid,
    output lpr_pkg::pix_t       pixel_x,
    output lpr_pkg::pix_t       pixel_y,
    output logic                visible,
    output logic                last
);
    import lpr_pkg::*;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    logic   state_reg;
    logic   state_next;
    coord_t x_reg;
    coord_t x_next;
    coord_t y_reg;
    coord_t y_next;
    coord_t xe_reg;
    coord_t ye_reg;
    coord_t dx_reg;
    coord_t dy_reg;
    logic   x_dec_reg;
    logic   y_dec_reg;
    err_t   err_reg;
    err_t   err_next;
    err_t   dx_e;
    err_t   dy_e;
    logic signed [ERR_W:0] e2;
    logic signed [ERR_W:0] dx_w;
    logic signed [ERR_W:0] dy_w;
    logic   done;
    logic   step_x;
    logic   step_y;
    logic   load;
    logic   valid_reg;
    pix_t   pixel_x_reg;
    pix_t   pixel_y_reg;
    logic   visible_reg;
    logic   last_reg;

    // Error term comparisons for one step.
    always_comb
    begin
        dx_e   = err_t'({{(ERR_W - COORD_W){1'b0}}, dx_reg});
        dy_e   = err_t'({{(ERR_W - COORD_W){1'b0}}, dy_reg});
        dx_w   = {1'b0, dx_e};
        dy_w   = {1'b0, dy_e};
        e2     = {err_reg, 1'b0};
        step_x = (e2 > -dy_w);
        step_y = (e2 < dx_w);
        done   = (x_reg == xe_reg) && (y_reg == ye_reg);
    end

    // Sequencer: take a new line when idle or when the current one finishes.
    always_comb
    begin
        load       = 1'b0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (!qstat.empty)
                begin
                    load       = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_WALK:
            begin
                if (done)
                begin
                    load       = !qstat.empty;
                    state_next = qstat.empty ? ST_IDLE : ST_WALK;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Next walk position and error term.
    always_comb
    begin
        x_next   = x_reg;
        y_next   = y_reg;
        err_next = err_reg;
        if (load)
        begin
            x_next   = head.x0;
            y_next   = head.y0;
            err_next = err_t'({{(ERR_W - COORD_W){1'b0}}, head.dx})
                     - err_t'({{(ERR_W - COORD_W){1'b0}}, head.dy});
        end
        else if (state_reg == ST_WALK && !done)
        begin
            if (step_x)
            begin
                x_next = x_dec_reg ? coord_t'(x_reg - 1'b1) : coord_t'(x_reg + 1'b1);
            end
            if (step_y)
            begin
                y_next = y_dec_reg ? coord_t'(y_reg - 1'b1) : coord_t'(y_reg + 1'b1);
            end
            err_next = err_reg - (step_x ? dy_e : '0) + (step_y ? dx_e : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= (state_reg == ST_WALK);
        end
    end

    // Walk registers and the registered result.
    always_ff @(posedge clk)
    begin
        x_reg   <= x_next;
        y_reg   <= y_next;
        err_reg <= err_next;
        if (load)
        begin
            xe_reg    <= head.x1;
            ye_reg    <= head.y1;
            dx_reg    <= head.dx;
            dy_reg    <= head.dy;
            x_dec_reg <= head.x_dec;
            y_dec_reg <= head.y_dec;
        end
        pixel_x_reg <= cfg.x_off + pix_t'({{(PIX_W - COORD_W){1'b0}}, x_reg});
        pixel_y_reg <= cfg.y_off + pix_t'({{(PIX_W - COORD_W){1'b0}}, y_reg});
        visible_reg <= (win_t'({{(WIN_W - COORD_W){1'b0}}, x_reg}) < cfg.win_w)
                    && (win_t'({{(WIN_W - COORD_W){1'b0}}, y_reg}) < cfg.win_h);
        last_reg    <= done;
    end

    assign pop          = load;
    assign active       = (state_reg == ST_WALK);
    assign result_valid = valid_reg;
    assign pixel_x      = pixel_x_reg;
    assign pixel_y      = pixel_y_reg;
    assign visible      = visible_reg;
    assign last         = last_reg;

endmodule

@@ design/line_pixel_rasterizer.sv @@
// Top level of the line pixel rasterizer: register port, front end, queue and walker.
`timescale 1ns / 1ps
// A line request (start_x, start_y, end_x, end_y) is taken at a rising edge with
// start high and busy low. Endpoints beyond the coordinate span saturate to its edge.
// Each point of the line, start and end included, comes out for one cycle with
// result_valid high: pixel_x/pixel_y are the point plus the offsets (mod 256),
// visible flags points inside the window, last marks the end point.
// With the walker idle, a request's first point passes through the queue, the walker's
// position registers and the output register. The walker then yields one point per
// cycle; a line has max(|dx|, |dy|) + 1 points, at most COORD_SPAN, and the walker's
// single error loop sets this rate. A queued line follows its predecessor with no gap.
// Two requests wait in the queue ahead of the walker; busy is high while it is full.
// The receiver cannot stall: every point is shown exactly once.
// Window and offsets are set through the APB port (width, height, x offset, y offset
// at 0x0, 0x4, 0x8, 0xC) by the user only while no line is in progress; not enforced.
// Reset clears the queue and the walker and sets a 64 by 64 window, zero offsets.

module line_pixel_rasterizer #(
    parameter int COORD_SPAN = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  start,
    output logic                  busy,
    input  lpr_pkg::coord_t       start_x,
    input  lpr_pkg::coord_t       start_y,
    input  lpr_pkg::coord_t       end_x,
    input  lpr_pkg::coord_t       end_y,
    output logic                  result_valid,
    output lpr_pkg::pix_t         pixel_x,
    output lpr_pkg::pix_t         pixel_y,
    output logic                  visible,
    output logic                  last
);
    import lpr_pkg::*;

`include "line_pixel_rasterizer_macros.svh"

    lpr_cfg_t   cfg_reg;
    lpr_cfg_t   cfg_next;
    logic       cfg_wr;
    logic [1:0] reg_idx;
    logic       push;
    logic       pop;
    logic       walk_active;
    lpr_cmd_t   front_cmd;
    lpr_cmd_t   head_cmd;
    lpr_qstat_t qstat;
    logic [1:0] q_count;

    // Configuration register writes.
    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            unique case (reg_idx)
                REG_WIN_W: cfg_next.win_w = pwdata[WIN_W-1:0];
                REG_WIN_H: cfg_next.win_h = pwdata[WIN_W-1:0];
                REG_X_OFF: cfg_next.x_off = pwdata[PIX_W-1:0];
                REG_Y_OFF: cfg_next.y_off = pwdata[PIX_W-1:0];
                default:   cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.win_w <= win_t'(64);
            cfg_reg.win_h <= win_t'(64);
            cfg_reg.x_off <= '0;
            cfg_reg.y_off <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // Register read-back.
    always_comb
    begin
        unique case (reg_idx)
            REG_WIN_W: prdata = {{(32 - WIN_W){1'b0}}, cfg_reg.win_w};
            REG_WIN_H: prdata = {{(32 - WIN_W){1'b0}}, cfg_reg.win_h};
            REG_X_OFF: prdata = {{(32 - PIX_W){1'b0}}, cfg_reg.x_off};
            REG_Y_OFF: prdata = {{(32 - PIX_W){1'b0}}, cfg_reg.y_off};
            default:   prdata = '0;
        endcase
    end

    lpr_front #(
        .COORD_SPAN (COORD_SPAN)
    ) u_front (
        .start   (start),
        .start_x (start_x),
        .start_y (start_y),
        .end_x   (end_x),
        .end_y   (end_y),
        .qstat   (qstat),
        .busy    (busy),
        .push    (push),
        .cmd     (front_cmd)
    );

    lpr_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wr_cmd (front_cmd),
        .pop    (pop),
        .head   (head_cmd),
        .qstat  (qstat),
        .count  (q_count)
    );

    lpr_walk u_walk (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .qstat        (qstat),
        .head         (head_cmd),
        .pop          (pop),
        .active       (walk_active),
        .result_valid (result_valid),
        .pixel_x      (pixel_x),
        .pixel_y      (pixel_y),
        .visible      (visible),
        .last         (last)
    );

    // Consistency checks on queue and walker.
    `LPR_ASSERT_IMPL(a_pop_nonempty, pop, q_count != 2'd0, "pop from an empty queue")
    `LPR_ASSERT_IMPL(a_count_bound, 1'b1, q_count != 2'd3, "queue count out of range")
    `LPR_ASSERT_IMPL(a_result_from_walk, result_valid, $past(walk_active), "result without walk")
    `LPR_ASSERT_NEXT(a_line_contiguous, result_valid && !last, result_valid, "gap inside a line")

endmodule
